>>> sv/bstk_pkg.sv
// ----------------------------------------------------------------------------
// Bounded stack package
// Shared types, sizes and helpers for the bounded stack with search.
// ----------------------------------------------------------------------------
package bstk_pkg;

   // Number of words the stack holds.
   localparam int DEPTH  = 8;
   // Entry count holds 0 to DEPTH; the address covers 0 to DEPTH-1.
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WORD_W = 32;
   localparam int NIB_W  = 4;

   typedef enum logic [1:0] {
      ACT_PUSH   = 2'd0,
      ACT_POP    = 2'd1,
      ACT_SEARCH = 2'd2,
      ACT_PEEK   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_RSVD      = 2'd3
   } status_type;

   // Index reported when a search finds nothing (all four bits set).
   localparam logic signed [NIB_W-1:0] NO_INDEX = '1;

   typedef struct packed {
      action_type               action;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] data;
      logic signed [NIB_W-1:0]  found_index;
      status_type               status;
      logic [NIB_W-1:0]         entry_count;
   } rsp_type;

   // Port controls for the entry memory.
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } mem_ctl_type;

   // Low four bits of a count-sized value, zero-extended first when narrower.
   function automatic logic [NIB_W-1:0] to_nib(input logic [CNT_W-1:0] v);
      logic [CNT_W+NIB_W-1:0] wide;
      wide = {{NIB_W{1'b0}}, v};
      return wide[NIB_W-1:0];
   endfunction

endpackage

>>> sv/bounded_stack_with_search_unit.sv
// ----------------------------------------------------------------------------
// Bounded stack with search
// LIFO stack of signed 32-bit words with push, pop, peek and search.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on rsp_item for one cycle with rsp_strobe high, and the receiver
// must take it then. The words live in a memory with a registered read. A
// push, and a pop, peek or search on an empty stack, finish straight from
// the dispatch state. A pop or peek on a non-empty stack passes through a
// read state for the top word. A search on a non-empty stack compares one
// stored word per cycle from the bottom entry up, and stops at the first
// match or after the top entry when nothing matches. The result strobe
// comes in the cycle busy falls, so a new item may be started right then.
module bounded_stack_with_search_unit
   import bstk_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   mem_ctl_type       mem_ctl;
   logic [WORD_W-1:0] mem_rd_data;

   // Sequencing and result building.
   bstk_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item),
      .mem_ctl     (mem_ctl),
      .mem_rd_data (mem_rd_data)
   );

   // Entry storage.
   bstk_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (mem_ctl.wr_en),
      .wr_addr (mem_ctl.wr_addr),
      .wr_data (mem_ctl.wr_data),
      .rd_addr (mem_ctl.rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

>>> sv/bstk_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module bstk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/bstk_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded stack controller
// Holds the entry count, sequences memory accesses and builds each result.
// ----------------------------------------------------------------------------
module bstk_ctrl
   import bstk_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_item,
   output logic              rsp_strobe,
   output rsp_type           rsp_item,
   output mem_ctl_type       mem_ctl,
   input  logic [WORD_W-1:0] mem_rd_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DISPATCH,
      S_READ,
      S_SCAN
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   req_type           req_ff, req_in;
   logic              strobe_ff, strobe_in;
   rsp_type           rsp_ff, rsp_in;

   logic              empty;
   logic              full;
   logic [CNT_W-1:0]  top_idx;
   logic [CNT_W-1:0]  idx_next;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign top_idx  = count_ff - 1'b1;
   assign idx_next = idx_ff + 1'b1;

   // Next state, memory controls and result.
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      req_in    = req_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;

      mem_ctl.wr_en   = 1'b0;
      mem_ctl.wr_addr = count_ff[ADDR_W-1:0];
      mem_ctl.wr_data = req_ff.value;
      mem_ctl.rd_addr = idx_next[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_item;
               state_in = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            rsp_in.data        = '0;
            rsp_in.found_index = NO_INDEX;
            rsp_in.status      = ST_OK;
            rsp_in.entry_count = to_nib(count_ff);
            case (req_ff.action)
               ACT_PUSH: begin
                  strobe_in = 1'b1;
                  state_in  = S_IDLE;
                  if (full) begin
                     rsp_in.status = ST_OVERFLOW;
                  end else begin
                     mem_ctl.wr_en      = 1'b1;
                     count_in           = count_ff + 1'b1;
                     rsp_in.entry_count = to_nib(count_in);
                  end
               end
               ACT_SEARCH: begin
                  mem_ctl.rd_addr = '0;
                  idx_in          = '0;
                  if (empty) begin
                     rsp_in.status = ST_UNDERFLOW;
                     strobe_in     = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  // Pop and peek both read the top entry.
                  mem_ctl.rd_addr = top_idx[ADDR_W-1:0];
                  if (empty) begin
                     rsp_in.status = ST_UNDERFLOW;
                     strobe_in     = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     state_in = S_READ;
                  end
               end
            endcase
         end

         S_READ: begin
            // The top word is now out of the memory.
            rsp_in.data = $signed(mem_rd_data);
            if (req_ff.action == ACT_POP) begin
               count_in = top_idx;
            end
            rsp_in.entry_count = to_nib(count_in);
            strobe_in          = 1'b1;
            state_in           = S_IDLE;
         end

         S_SCAN: begin
            // Compare one entry per cycle while the next read is under way.
            idx_in = idx_next;
            if (mem_rd_data == req_ff.value) begin
               rsp_in.found_index = $signed(to_nib(idx_ff));
               strobe_in          = 1'b1;
               state_in           = S_IDLE;
            end else if (idx_next == count_ff) begin
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      idx_ff <= idx_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

>>> verif/tb_bounded_stack_with_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded stack with search testbench
// Drives push, pop, search and peek items into the stack and keeps its own
// copy of the stack contents to predict every reply. Each reply is compared
// field by field with the oldest prediction. A short directed part covers the
// empty and full corners first. Random traffic follows, with runs that fill
// and drain the stack, bursts of sender idling and a pause until all replies
// are back. A final back-to-back part runs with no idling.
// ----------------------------------------------------------------------------
module tb_bounded_stack_with_search_unit;
   import bstk_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = DEPTH + 4;
   localparam int REPORT_LIMIT  = 10;

   localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // Shadow copy of the stack, updated as each item is accepted.
   logic signed [WORD_W-1:0] shadow_words [DEPTH];
   int shadow_fill = 0;

   // Replies predicted for accepted items, oldest first.
   rsp_type replies_due [$];

   int fail_count  = 0;
   int cycle_count = 0;
   int idle_pct    = 0;

   bounded_stack_with_search_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Apply one item to the shadow stack and return the reply it should give.
   function automatic rsp_type advance_shadow_stack(input action_type act,
                                                    input logic signed [WORD_W-1:0] val);
      rsp_type r;
      int i;
      logic hit;
      r.data = '0;
      r.found_index = NO_INDEX;
      r.status = ST_OK;
      hit = 1'b0;
      case (act)
         ACT_PUSH: begin
            if (shadow_fill >= DEPTH) begin
               r.status = ST_OVERFLOW;
            end else begin
               shadow_words[shadow_fill] = val;
               shadow_fill++;
            end
         end
         ACT_POP: begin
            if (shadow_fill == 0) begin
               r.status = ST_UNDERFLOW;
            end else begin
               shadow_fill--;
               r.data = shadow_words[shadow_fill];
            end
         end
         ACT_SEARCH: begin
            if (shadow_fill == 0) begin
               r.status = ST_UNDERFLOW;
            end else begin
               // The lowest matching index wins.
               for (i = 0; i < shadow_fill; i++) begin
                  if (!hit && shadow_words[i] == val) begin
                     hit = 1'b1;
                     r.found_index = i[NIB_W-1:0];
                  end
               end
            end
         end
         default: begin
            if (shadow_fill == 0) begin
               r.status = ST_UNDERFLOW;
            end else begin
               r.data = shadow_words[shadow_fill-1];
            end
         end
      endcase
      r.entry_count = shadow_fill[NIB_W-1:0];
      return r;
   endfunction

   task automatic log_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%0t: %s", $time, msg);
      end
   endtask

   // Compare every reply with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (replies_due.size() == 0) begin
            log_failure($sformatf("reply with no item outstanding: %h", rsp_item));
         end else begin
            want = replies_due.pop_front();
            if (rsp_item.data !== want.data) begin
               log_failure($sformatf("data: expected %0d, got %0d",
                                     want.data, rsp_item.data));
            end
            if (rsp_item.found_index !== want.found_index) begin
               log_failure($sformatf("found_index: expected %0d, got %0d",
                                     want.found_index, rsp_item.found_index));
            end
            if (rsp_item.status !== want.status) begin
               log_failure($sformatf("status: expected %0d, got %0d",
                                     want.status, rsp_item.status));
            end
            if (rsp_item.entry_count !== want.entry_count) begin
               log_failure($sformatf("entry_count: expected %0d, got %0d",
                                     want.entry_count, rsp_item.entry_count));
            end
         end
      end
   end

   // Send one item, with an optional idle burst ahead of it. Start is left
   // high on return so that a following item goes out back to back.
   task automatic send_item(input action_type act, input logic signed [WORD_W-1:0] val);
      req_type item;
      item.action = act;
      item.value = val;
      if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_item <= item;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      replies_due.push_back(advance_shadow_stack(act, val));
   endtask

   // Stop sending and let every outstanding reply come back.
   task automatic wait_until_drained();
      start <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Value mix: words already on the stack, small values that repeat,
   // the extremes, and fully random words.
   function automatic logic signed [WORD_W-1:0] pick_value(input int stacked_pct);
      logic signed [WORD_W-1:0] v;
      if (shadow_fill > 0 && $urandom_range(1, 100) <= stacked_pct) begin
         v = shadow_words[$urandom_range(0, shadow_fill - 1)];
      end else begin
         case ($urandom_range(0, 3))
            0: begin
               v = $urandom_range(0, 7);
               v = v - 4;
            end
            1: begin
               case ($urandom_range(0, 3))
                  0: v = WORD_MIN;
                  1: v = WORD_MAX;
                  2: v = '0;
                  default: v = '1;
               endcase
            end
            default: v = $urandom();
         endcase
      end
      return v;
   endfunction

   task automatic send_random_item(input int push_pct);
      action_type act;
      if ($urandom_range(1, 100) <= push_pct) begin
         act = ACT_PUSH;
      end else begin
         case ($urandom_range(0, 5))
            0, 1, 2: act = ACT_POP;
            3, 4:    act = ACT_SEARCH;
            default: act = ACT_PEEK;
         endcase
      end
      send_item(act, pick_value((act == ACT_SEARCH) ? 60 : 15));
   endtask

   // Corners: empty stack, extreme words, duplicates, full stack.
   task automatic test_directed();
      idle_pct = 30;
      send_item(ACT_POP, $urandom());
      send_item(ACT_PEEK, $urandom());
      send_item(ACT_SEARCH, $urandom());
      send_item(ACT_PUSH, WORD_MIN);
      send_item(ACT_PUSH, WORD_MAX);
      send_item(ACT_PUSH, '0);
      send_item(ACT_PUSH, '1);
      send_item(ACT_PUSH, WORD_MIN);
      // A duplicate must report its lowest index.
      send_item(ACT_SEARCH, WORD_MIN);
      send_item(ACT_SEARCH, 32'sd5);
      send_item(ACT_PEEK, $urandom());
      send_item(ACT_PUSH, 32'sh5555_5555);
      send_item(ACT_PUSH, 32'shAAAA_AAAA);
      send_item(ACT_PUSH, 32'sh1234_5678);
      // The stack is full now, so this push is dropped.
      send_item(ACT_PUSH, 32'sd1);
      send_item(ACT_SEARCH, 32'sh1234_5678);
      repeat (DEPTH + 1) send_item(ACT_POP, $urandom());
   endtask

   // Segments that lean toward filling, draining or neither, each with its
   // own amount of sender idling.
   task automatic test_random_traffic();
      int sent;
      int seg_len;
      int push_pct;
      int k;
      sent = 0;
      while (sent < 1250) begin
         seg_len = $urandom_range(20, 60);
         case ($urandom_range(0, 2))
            0: push_pct = 75;
            1: push_pct = 20;
            default: push_pct = 50;
         endcase
         idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
         for (k = 0; k < seg_len; k++) send_random_item(push_pct);
         sent += seg_len;
      end
   endtask

   // Hold the sender off until every reply is back, then carry on.
   task automatic test_pause_and_resume();
      idle_pct = 25;
      repeat (60) send_random_item(50);
      wait_until_drained();
      repeat (60) send_random_item(50);
   endtask

   // Back-to-back items with no idling to close the run.
   task automatic test_back_to_back();
      idle_pct = 0;
      repeat (40) send_random_item(75);
      repeat (40) send_random_item(20);
      repeat (70) send_random_item(50);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic();
      test_pause_and_resume();
      test_back_to_back();
      wait_until_drained();
      if (fail_count == 0 && replies_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
